FILE: hw/rtl/bgra_pair_pack_to_uyvy_uyva_macros.svh
// ----------------------------------------------------------------------------
// BGRA pair packer assertion macros
// Shared concurrent checks, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BGRA_PAIR_PACK_TO_UYVY_UYVA_MACROS_SVH
`define BGRA_PAIR_PACK_TO_UYVY_UYVA_MACROS_SVH

// same-cycle implication
`define BPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpp same-cycle check failed");

// next-cycle implication
`define BPP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpp next-cycle check failed");

`endif

FILE: hw/rtl/bpp_pkg.sv
// ----------------------------------------------------------------------------
// BGRA pair packer package
// Beat types, pack mode codes and fixed-point coefficient helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

  localparam int COEFF_FRACTION_BITS_DFLT = 16;

  localparam logic [7:0] BYTE_MAX  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [3:0] COUNT_FULL = 4'd8;
  localparam logic [3:0] COUNT_HALF = 4'd4;

  typedef enum logic [1:0] {
    MODE_BGRA = 2'd0,
    MODE_BGRX = 2'd1,
    MODE_UYVY = 2'd2,
    MODE_UYVA = 2'd3
  } pack_mode_t;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] alpha_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic [7:0] alpha_second;
    logic       has_second;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] packed_byte_0;
    logic [7:0] packed_byte_1;
    logic [7:0] packed_byte_2;
    logic [7:0] packed_byte_3;
    logic [7:0] packed_byte_4;
    logic [7:0] packed_byte_5;
    logic [7:0] packed_byte_6;
    logic [7:0] packed_byte_7;
    logic [7:0] plane_alpha_0;
    logic [7:0] plane_alpha_1;
    logic [3:0] packed_count;
  } out_beat_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } pipe_en_t;

  function automatic longint coeff_fix(input int thousandths, input int frac_bits);
    longint mag;
    longint k;
    mag = (thousandths < 0) ? -longint'(thousandths) : longint'(thousandths);
    k = (mag * (longint'(1) << frac_bits) + 500) / 1000;
    return (thousandths < 0) ? -k : k;
  endfunction

  function automatic longint chroma_offset(input int frac_bits);
    return longint'(255) << (frac_bits - 1);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bgra_pair_pack_to_uyvy_uyva.sv
// Registered stages from input beat acceptance to out_valid: multiply, sum/clamp, merge.
// Throughput: a pixel pair per clock unless stalled; lanes Y0, Y1, U, V run in parallel.
// Stalls back up the three-stage pipeline; in_stall marks a full, blocked first stage.
// Reset (rst_n low, synchronous) empties the pipeline and sets pack_mode to BGRA.
// ----------------------------------------------------------------------------
// BGRA pair packer top level
// Packs a BGRA pixel pair as BGRA, BGRX, UYVY or UYVY with alpha plane.
// ----------------------------------------------------------------------------
`default_nettype none

module bgra_pair_pack_to_uyvy_uyva #(
  parameter int COEFF_FRACTION_BITS = bpp_pkg::COEFF_FRACTION_BITS_DFLT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bpp_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bpp_pkg::out_beat_t     out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_wr_data
);

  import bpp_pkg::*;

  `include "bgra_pair_pack_to_uyvy_uyva_macros.svh"

  localparam longint K_Y_R = coeff_fix(299, COEFF_FRACTION_BITS);
  localparam longint K_Y_G = coeff_fix(587, COEFF_FRACTION_BITS);
  localparam longint K_Y_B = coeff_fix(114, COEFF_FRACTION_BITS);
  localparam longint K_U_R = coeff_fix(-169, COEFF_FRACTION_BITS);
  localparam longint K_U_G = coeff_fix(-331, COEFF_FRACTION_BITS);
  localparam longint K_U_B = coeff_fix(500, COEFF_FRACTION_BITS);
  localparam longint K_V_R = coeff_fix(500, COEFF_FRACTION_BITS);
  localparam longint K_V_G = coeff_fix(-419, COEFF_FRACTION_BITS);
  localparam longint K_V_B = coeff_fix(-81, COEFF_FRACTION_BITS);
  localparam longint C_OFS = chroma_offset(COEFF_FRACTION_BITS);

  pack_mode_t mode_r;
  logic       v1_r, v2_r, vo_r;
  logic       rdy1, rdy2, rdy_o;
  in_beat_t   beat_a_r, beat_b_r;
  pipe_en_t   lane_en;
  logic [7:0] red_y1, green_y1, blue_y1;
  logic [7:0] u_byte, y0_byte, v_byte, y1_byte;

  assign rdy_o = !vo_r || !out_stall;
  assign rdy2  = !v2_r || rdy_o;
  assign rdy1  = !v1_r || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = vo_r;

  assign lane_en = '{mul_en: rdy1, sum_en: rdy2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BGRA;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      vo_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= pack_mode_t'(cfg_wr_data);
      end
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy_o) begin
        vo_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      beat_a_r <= in_data;
    end
    if (rdy2) begin
      beat_b_r <= beat_a_r;
    end
  end

  // duplicate the first pixel when the second is absent
  assign red_y1   = in_data.has_second ? in_data.red_second   : in_data.red_first;
  assign green_y1 = in_data.has_second ? in_data.green_second : in_data.green_first;
  assign blue_y1  = in_data.has_second ? in_data.blue_second  : in_data.blue_first;

  bpp_lane #(
    .FRAC_BITS(COEFF_FRACTION_BITS), .K_RED(K_Y_R), .K_GREEN(K_Y_G), .K_BLUE(K_Y_B),
    .OFFSET(0)
  ) u_lane_y0 (
    .clk(clk), .en(lane_en), .red_in(in_data.red_first), .green_in(in_data.green_first),
    .blue_in(in_data.blue_first), .byte_out(y0_byte)
  );

  bpp_lane #(
    .FRAC_BITS(COEFF_FRACTION_BITS), .K_RED(K_Y_R), .K_GREEN(K_Y_G), .K_BLUE(K_Y_B),
    .OFFSET(0)
  ) u_lane_y1 (
    .clk(clk), .en(lane_en), .red_in(red_y1), .green_in(green_y1),
    .blue_in(blue_y1), .byte_out(y1_byte)
  );

  bpp_lane #(
    .FRAC_BITS(COEFF_FRACTION_BITS), .K_RED(K_U_R), .K_GREEN(K_U_G), .K_BLUE(K_U_B),
    .OFFSET(C_OFS)
  ) u_lane_u (
    .clk(clk), .en(lane_en), .red_in(in_data.red_first), .green_in(in_data.green_first),
    .blue_in(in_data.blue_first), .byte_out(u_byte)
  );

  bpp_lane #(
    .FRAC_BITS(COEFF_FRACTION_BITS), .K_RED(K_V_R), .K_GREEN(K_V_G), .K_BLUE(K_V_B),
    .OFFSET(C_OFS)
  ) u_lane_v (
    .clk(clk), .en(lane_en), .red_in(in_data.red_first), .green_in(in_data.green_first),
    .blue_in(in_data.blue_first), .byte_out(v_byte)
  );

  bpp_merge u_merge (
    .clk(clk), .load(rdy_o), .mode(mode_r), .beat(beat_b_r),
    .u_byte(u_byte), .y0_byte(y0_byte), .v_byte(v_byte), .y1_byte(y1_byte),
    .out_data(out_data)
  );

  `BPP_ASSERT_NXT(a_accept_fills, in_valid && !in_stall, v1_r)
  `BPP_ASSERT_IMP(a_full_stalls, v1_r && v2_r && vo_r && out_stall, in_stall)
  `BPP_ASSERT_IMP(a_half_zero_tail, out_valid && out_data.packed_count != COUNT_FULL,
    out_data.packed_byte_4 == BYTE_ZERO && out_data.packed_byte_7 == BYTE_ZERO)
  `BPP_ASSERT_IMP(a_plane_alpha_yuv,
    out_valid && (out_data.plane_alpha_0 != BYTE_ZERO || out_data.plane_alpha_1 != BYTE_ZERO),
    out_data.packed_count == COUNT_HALF)

endmodule

`default_nettype wire

FILE: hw/rtl/bpp_lane.sv
// ----------------------------------------------------------------------------
// BGRA pair packer color lane
// Weighted sum of one RGB triple: registered products, then sum, offset,
// truncate and clamp to a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_lane #(
  parameter int     FRAC_BITS = bpp_pkg::COEFF_FRACTION_BITS_DFLT,
  parameter longint K_RED     = 0,
  parameter longint K_GREEN   = 0,
  parameter longint K_BLUE    = 0,
  parameter longint OFFSET    = 0
) (
  input  wire logic              clk,
  input  wire bpp_pkg::pipe_en_t en,
  input  wire logic [7:0]        red_in,
  input  wire logic [7:0]        green_in,
  input  wire logic [7:0]        blue_in,
  output logic [7:0]             byte_out
);

  import bpp_pkg::*;

  localparam int CW = FRAC_BITS + 1;
  localparam int PW = CW + 9;
  localparam int AW = FRAC_BITS + 11;

  localparam logic signed [CW-1:0] KR = CW'(K_RED);
  localparam logic signed [CW-1:0] KG = CW'(K_GREEN);
  localparam logic signed [CW-1:0] KB = CW'(K_BLUE);
  localparam logic signed [AW-1:0] OFS = AW'(OFFSET);

  logic signed [PW-1:0] prod_red_nxt, prod_green_nxt, prod_blue_nxt;
  logic signed [PW-1:0] prod_red_r, prod_green_r, prod_blue_r;
  logic signed [AW-1:0] acc;
  logic        [AW-FRAC_BITS-2:0] quot;
  logic        [7:0]    byte_nxt;
  logic        [7:0]    byte_r;

  assign prod_red_nxt   = PW'($signed({1'b0, red_in}))   * PW'(KR);
  assign prod_green_nxt = PW'($signed({1'b0, green_in})) * PW'(KG);
  assign prod_blue_nxt  = PW'($signed({1'b0, blue_in}))  * PW'(KB);

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      prod_red_r   <= prod_red_nxt;
      prod_green_r <= prod_green_nxt;
      prod_blue_r  <= prod_blue_nxt;
    end
  end

  always_comb begin
    acc  = AW'(prod_red_r) + AW'(prod_green_r) + AW'(prod_blue_r) + OFS;
    quot = acc[AW-2:FRAC_BITS];
    if (acc[AW-1]) begin
      byte_nxt = BYTE_ZERO;
    end else if (|quot[AW-FRAC_BITS-2:8]) begin
      byte_nxt = BYTE_MAX;
    end else begin
      byte_nxt = quot[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bpp_merge.sv
// ----------------------------------------------------------------------------
// BGRA pair packer merge stage
// Combines lane results and passthrough bytes per pack mode into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_merge (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire bpp_pkg::pack_mode_t mode,
  input  wire bpp_pkg::in_beat_t   beat,
  input  wire logic [7:0]          u_byte,
  input  wire logic [7:0]          y0_byte,
  input  wire logic [7:0]          v_byte,
  input  wire logic [7:0]          y1_byte,
  output bpp_pkg::out_beat_t       out_data
);

  import bpp_pkg::*;

  out_beat_t out_nxt;
  out_beat_t out_r;

  always_comb begin
    out_nxt = '0;
    unique case (mode)
      MODE_BGRA, MODE_BGRX: begin
        out_nxt.packed_byte_0 = beat.blue_first;
        out_nxt.packed_byte_1 = beat.green_first;
        out_nxt.packed_byte_2 = beat.red_first;
        out_nxt.packed_byte_3 = (mode == MODE_BGRX) ? BYTE_MAX : beat.alpha_first;
        out_nxt.packed_count  = COUNT_HALF;
        if (beat.has_second) begin
          out_nxt.packed_byte_4 = beat.blue_second;
          out_nxt.packed_byte_5 = beat.green_second;
          out_nxt.packed_byte_6 = beat.red_second;
          out_nxt.packed_byte_7 = (mode == MODE_BGRX) ? BYTE_MAX : beat.alpha_second;
          out_nxt.packed_count  = COUNT_FULL;
        end
      end
      MODE_UYVY, MODE_UYVA: begin
        out_nxt.packed_byte_0 = u_byte;
        out_nxt.packed_byte_1 = y0_byte;
        out_nxt.packed_byte_2 = v_byte;
        out_nxt.packed_byte_3 = y1_byte;
        out_nxt.packed_count  = COUNT_HALF;
        if (mode == MODE_UYVA) begin
          out_nxt.plane_alpha_0 = beat.alpha_first;
          out_nxt.plane_alpha_1 = beat.has_second ? beat.alpha_second : BYTE_ZERO;
        end
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire
